FILE: hdl/ksa_pkg.sv
// shared constants, codes and controller/datapath types for the keyed sum aggregator
package ksa_pkg;

  // default field widths
  localparam int KEY_BITS_DEF    = 10;
  localparam int WEIGHT_BITS_DEF = 10;
  localparam int SUM_BITS_DEF    = 20;

  // input command codes
  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } ksa_op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_RD_ROW,
    ST_RD_OUT
  } ksa_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic add_issue;    // latch add word, read sum and mark row
    logic add_commit;   // write saturated sum and set mark
    logic find_issue;   // pick first busy row, read its marks
    logic find_take;    // pick first mark, clear it, read its sum
    logic result_load;  // move result into the output register
  } ksa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic any_present;  // at least one key is present
    logic out_free;     // output register can take a word this cycle
  } ksa_sts_t;

endpackage

FILE: hdl/ksa_in_if.sv
// input channel: command word with key and weight
interface ksa_in_if #(
  parameter int KEY_BITS    = 10,
  parameter int WEIGHT_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [KEY_BITS-1:0]    item_key;
  logic [WEIGHT_BITS-1:0] item_weight;

  modport source (output valid, output cmd, output item_key, output item_weight, input ready);
  modport sink   (input valid, input cmd, input item_key, input item_weight, output ready);
endinterface

FILE: hdl/ksa_out_if.sv
// output channel: one result word per read command
interface ksa_out_if #(
  parameter int KEY_BITS = 10,
  parameter int SUM_BITS = 20
);
  logic                valid;
  logic                ready;
  logic                found;
  logic [KEY_BITS-1:0] out_key;
  logic [SUM_BITS-1:0] total;

  modport source (output valid, output found, output out_key, output total, input ready);
  modport sink   (input valid, input found, input out_key, input total, output ready);
endinterface

FILE: hdl/ksa_ctrl.sv
// controller state machine sequencing add and read commands
module ksa_ctrl
  import ksa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_cmd_i,
  output logic     in_ready_o,
  input  ksa_sts_t sts_i,
  output ksa_cmd_t cmd_o
);

  ksa_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_READ) begin
            cmd_o.find_issue = 1'b1;
            state_d = sts_i.any_present ? ST_RD_ROW : ST_RD_OUT;
          end else begin
            cmd_o.add_issue = 1'b1;
            state_d = ST_ADD_WR;
          end
        end
      end
      ST_ADD_WR: begin
        cmd_o.add_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD_ROW: begin
        cmd_o.find_take = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ksa_dpath.sv
// datapath: sum memory, mark rows, busy-row summary, encoders and output register
module ksa_dpath
  import ksa_pkg::*;
#(
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [KEY_BITS-1:0]    item_key_i,
  input  logic [WEIGHT_BITS-1:0] item_weight_i,
  input  ksa_cmd_t               cmd_i,
  output ksa_sts_t               sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [KEY_BITS-1:0]    out_key_o,
  output logic [SUM_BITS-1:0]    total_o
);

  localparam int COL_BITS = (KEY_BITS + 1) / 2;
  localparam int ROW_BITS = KEY_BITS - COL_BITS;
  localparam int ROWS     = 1 << ROW_BITS;
  localparam int COLS     = 1 << COL_BITS;
  localparam int DEPTH    = 1 << KEY_BITS;
  localparam int ADD_BITS = ((SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS) + 1;

  // storage: marks kept in rows, a row is only meaningful while its busy bit is set
  logic [COLS-1:0]     mark_mem [ROWS];
  logic [SUM_BITS-1:0] sum_mem  [DEPTH];
  logic [ROWS-1:0]     busy_rows_q, busy_rows_d;

  logic [COLS-1:0]        mark_rd_q;
  logic [SUM_BITS-1:0]    sum_rd_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic                   found_q;

  logic                out_valid_q;
  logic                out_found_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [SUM_BITS-1:0] out_total_q;

  logic [ROW_BITS-1:0] key_row, first_row, mark_raddr;
  logic [COL_BITS-1:0] key_col, first_col;
  logic                any_row;
  logic [COLS-1:0]     cur_row, mark_wdata;
  logic                mark_we, mark_re, sum_re, hit;
  logic [KEY_BITS-1:0] sum_raddr;
  logic [SUM_BITS-1:0] base, sat_sum;
  logic [ADD_BITS-1:0] sum_wide;

  assign key_row = key_q[KEY_BITS-1:COL_BITS];
  assign key_col = key_q[COL_BITS-1:0];

  // lowest busy row
  always_comb begin
    first_row = '0;
    any_row   = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (busy_rows_q[r]) begin
        first_row = ROW_BITS'(r);
        any_row   = 1'b1;
      end
    end
  end

  // lowest mark inside the row just read
  always_comb begin
    first_col = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (mark_rd_q[c]) begin
        first_col = COL_BITS'(c);
      end
    end
  end

  // add: current row and total, treating an idle row as empty
  assign cur_row  = busy_rows_q[key_row] ? mark_rd_q : '0;
  assign hit      = cur_row[key_col];
  assign base     = hit ? sum_rd_q : '0;
  assign sum_wide = ADD_BITS'(base) + ADD_BITS'(weight_q);
  assign sat_sum  = (|sum_wide[ADD_BITS-1:SUM_BITS]) ? {SUM_BITS{1'b1}}
                                                      : sum_wide[SUM_BITS-1:0];

  // memory port control
  assign mark_re    = cmd_i.add_issue | cmd_i.find_issue;
  assign mark_raddr = cmd_i.add_issue ? item_key_i[KEY_BITS-1:COL_BITS] : first_row;
  assign mark_we    = cmd_i.add_commit | cmd_i.find_take;
  assign mark_wdata = cmd_i.add_commit ? (cur_row | (COLS'(1) << key_col))
                                       : (mark_rd_q & ~(COLS'(1) << first_col));
  assign sum_re     = cmd_i.add_issue | cmd_i.find_take;
  assign sum_raddr  = cmd_i.add_issue ? item_key_i : {key_row, first_col};

  // mark row memory
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[key_row] <= mark_wdata;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_raddr];
    end
  end

  // sum memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_commit) begin
      sum_mem[key_q] <= sat_sum;
    end
    if (sum_re) begin
      sum_rd_q <= sum_mem[sum_raddr];
    end
  end

  // busy-row summary
  always_comb begin
    busy_rows_d = busy_rows_q;
    if (mark_we) begin
      busy_rows_d[key_row] = cmd_i.add_commit | (|mark_wdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_rows_q <= '0;
    end else begin
      busy_rows_q <= busy_rows_d;
    end
  end

  // working key, weight and found flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_issue) begin
      key_q    <= item_key_i;
      weight_q <= item_weight_i;
    end else if (cmd_i.find_issue) begin
      key_q   <= {first_row, {COL_BITS{1'b0}}};
      found_q <= any_row;
    end else if (cmd_i.find_take) begin
      key_q <= {key_row, first_col};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_found_q <= found_q;
      out_key_q   <= found_q ? key_q : '0;
      out_total_q <= found_q ? sum_rd_q : '0;
    end
  end

  assign sts_o.any_present = any_row;
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign out_key_o   = out_key_q;
  assign total_o     = out_total_q;

endmodule

FILE: hdl/keyed_sum_aggregator_unit.sv
// top level of the keyed sum aggregator: controller plus datapath
// Group-by-key summation. An add word (cmd 0) adds item_weight into the running total of
// item_key, saturating at the largest total, and marks the key present; it gives no result.
// A read word (cmd 1) returns the smallest present key with its total and removes it, or
// found = 0 with zero key and total when nothing is present. Items are handled one at a time:
// an add reads the sum memory and its mark row and writes both back; a read does the busy-row
// search and mark-row read, then the sum memory read (skipped when nothing is present), then
// waits while a previous result still sits unclaimed in the output register. Keys are found by
// a two-level search: a flip-flop busy bit per row of marks, then the marks of that row. Reset
// takes effect at once; the sum memory and mark rows need no clearing pass.
module keyed_sum_aggregator_unit
  import ksa_pkg::*;
#(
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input logic    clk_i,
  input logic    rst_ni,
  ksa_in_if.sink   in_i,
  ksa_out_if.source out_o
);

  ksa_cmd_t cmd;
  ksa_sts_t sts;

  // sequencing
  ksa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result path
  ksa_dpath #(
    .KEY_BITS    (KEY_BITS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_key_i    (in_i.item_key),
    .item_weight_i (in_i.item_weight),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .found_o       (out_o.found),
    .out_key_o     (out_o.out_key),
    .total_o       (out_o.total)
  );

endmodule

FILE: hdl/ksa_checker.sv
// port-level checks for the keyed sum aggregator and their bind
module ksa_checker #(
  parameter int KEY_BITS = 10,
  parameter int SUM_BITS = 20
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_cmd_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                found_i,
  input logic [KEY_BITS-1:0] out_key_i,
  input logic [SUM_BITS-1:0] total_i
);

  logic in_acc, rd_acc;

  assign in_acc = in_valid_i & in_ready_i;
  assign rd_acc = in_acc & in_cmd_i;

  // an empty read reports zero key and total
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> out_key_i == '0 && total_i == '0)
    else $error("empty read result carries nonzero fields");

  // a fresh result follows an accepted read
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(rd_acc, 2) || $past(rd_acc, 3))
    else $error("result word without a matching read");

  // one word at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted while previous word still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i) &&
      $stable(out_key_i) && $stable(total_i))
    else $error("stalled result word changed");

endmodule

bind keyed_sum_aggregator_unit ksa_checker #(
  .KEY_BITS (KEY_BITS),
  .SUM_BITS (SUM_BITS)
) u_ksa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .found_i     (out_o.found),
  .out_key_i   (out_o.out_key),
  .total_i     (out_o.total)
);

FILE: tb/sv/keyed_sum_aggregator_unit_tb.sv
// self-checking testbench for the keyed sum aggregator: directed table, then random traffic
`timescale 1ns / 1ps

module keyed_sum_aggregator_unit_tb;
  import ksa_pkg::*;

  localparam int KEY_W     = KEY_BITS_DEF;
  localparam int WEIGHT_W  = WEIGHT_BITS_DEF;
  localparam int SUM_W     = SUM_BITS_DEF;
  localparam int KEY_SLOTS = 1 << KEY_W;
  localparam logic [KEY_W-1:0]    KEY_MAX    = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_WORDS = 100;

  // one result word: merged pair or empty marker
  typedef struct packed {
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [SUM_W-1:0]   total;
  } pair_t;

  // directed stimulus row, with the result typed in where it is obvious
  typedef struct packed {
    ksa_op_e               op;
    logic [KEY_W-1:0]      key;
    logic [WEIGHT_W-1:0]   weight;
    logic                  typed;
    pair_t                 want;
  } dir_row_t;

  localparam int DIR_LEN = 23;

  dir_row_t dir_rows [DIR_LEN] = '{
    // read straight after reset finds nothing
    '{CMD_READ, 10'd0,    10'd0,    1'b1, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd1023, 10'd1023, 1'b0, '{1'b0, 10'd0,    20'd0}},
    // zero weight still makes the key present
    '{CMD_ADD,  10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b1, '{1'b1, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b1, '{1'b1, 10'd1023, 20'd1023}},
    // key and weight ignored on a read of an empty table
    '{CMD_READ, 10'd1023, 10'd1023, 1'b1, '{1'b0, 10'd0,    20'd0}},
    // add then read of the same key back to back
    '{CMD_ADD,  10'd7,    10'd3,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd7,    10'd9,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd7,    10'd9,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd682,  10'd341,  1'b0, '{1'b0, 10'd0,    20'd0}},
    // alternating bit patterns, drained in key order
    '{CMD_ADD,  10'd341,  10'd682,  1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd682,  10'd341,  1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd1,    10'd1023, 1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd1022, 10'd512,  1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd341,  10'd1,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b1, '{1'b0, 10'd0,    20'd0}},
    '{CMD_ADD,  10'd0,    10'd1023, 1'b0, '{1'b0, 10'd0,    20'd0}},
    '{CMD_READ, 10'd0,    10'd0,    1'b1, '{1'b1, 10'd0,    20'd1023}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ksa_in_if  #(.KEY_BITS(KEY_W), .WEIGHT_BITS(WEIGHT_W)) cmd_bus ();
  ksa_out_if #(.KEY_BITS(KEY_W), .SUM_BITS(SUM_W))       res_bus ();

  keyed_sum_aggregator_unit #(
    .KEY_BITS   (KEY_W),
    .WEIGHT_BITS(WEIGHT_W),
    .SUM_BITS   (SUM_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_bus),
    .out_o (res_bus)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // running totals and present marks as the block should hold them
  logic [SUM_W-1:0] key_totals [KEY_SLOTS];
  logic             key_marks  [KEY_SLOTS];
  int               live_keys;
  pair_t            owed_pairs [$];
  int               mismatch_count;
  int               src_idle_pct;
  int               snk_stall_pct;
  int               snk_hold_req;

  // merge one accepted word into the totals, give the result word of a read
  task automatic merge_word(input ksa_op_e op, input logic [KEY_W-1:0] k,
                            input logic [WEIGHT_W-1:0] w,
                            output logic has_pair, output pair_t pair);
    logic [SUM_W:0] grown;
    has_pair = 1'b0;
    pair     = '0;
    if (op == CMD_ADD) begin
      grown = {1'b0, key_totals[k]} + (SUM_W+1)'(w);
      key_totals[k] = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
      if (!key_marks[k]) live_keys++;
      key_marks[k] = 1'b1;
    end else begin
      has_pair = 1'b1;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (key_marks[i]) begin
          pair.found    = 1'b1;
          pair.key      = KEY_W'(i);
          pair.total    = key_totals[i];
          key_totals[i] = '0;
          key_marks[i]  = 1'b0;
          live_keys--;
          break;
        end
      end
    end
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom_range(KEY_SLOTS - 1));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int base, input int span);
    return KEY_W'(base + int'($urandom_range(span - 1)));
  endfunction

  // weights lean toward the extremes
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return WEIGHT_MAX;
      default: return WEIGHT_W'($urandom_range(int'(WEIGHT_MAX)));
    endcase
  endfunction

  // offer one word after a random gap, wait for the handshake, predict its result
  task automatic send_word(input ksa_op_e op, input logic [KEY_W-1:0] k,
                           input logic [WEIGHT_W-1:0] w,
                           input logic typed, input pair_t want);
    int    gap;
    logic  has_pair;
    pair_t pair;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd         <= op;
    cmd_bus.item_key    <= k;
    cmd_bus.item_weight <= w;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    merge_word(op, k, w, has_pair, pair);
    if (has_pair) owed_pairs.insert(owed_pairs.size(), typed ? want : pair);
  endtask

  // drop valid, let every owed result come back and the block settle
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    while (owed_pairs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // one short sequence of related words
  task automatic run_episode(inout int words_sent);
    int base;
    int span;
    int count;
    logic [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: begin
        // fill a key window, then drain all present keys and sometimes read once more
        case ($urandom_range(2))
          0: span = 4;
          1: span = 32;
          default: span = KEY_SLOTS;
        endcase
        base  = $urandom_range(KEY_SLOTS - 1);
        count = $urandom_range(1, 12);
        repeat (count) send_word(CMD_ADD, pick_key(base, span), pick_weight(), 1'b0, '0);
        words_sent += count;
        count = live_keys + int'($urandom_range(1));
        repeat (count) send_word(CMD_READ, any_key(), pick_weight(), 1'b0, '0);
        words_sent += count;
      end
      1: begin
        // adds and reads mixed
        count = $urandom_range(4, 16);
        repeat (count) begin
          if ($urandom_range(9) < 6) send_word(CMD_ADD, any_key(), pick_weight(), 1'b0, '0);
          else send_word(CMD_READ, any_key(), pick_weight(), 1'b0, '0);
        end
        words_sent += count;
      end
      2: begin
        // raw random words
        count = $urandom_range(1, 4);
        repeat (count)
          send_word(ksa_op_e'($urandom_range(1)), any_key(),
                    WEIGHT_W'($urandom_range(int'(WEIGHT_MAX))), 1'b0, '0);
        words_sent += count;
      end
      default: begin
        // same key hit back to back, then a read
        k     = any_key();
        count = $urandom_range(1, 6);
        repeat (count) send_word(CMD_ADD, k, pick_weight(), 1'b0, '0);
        send_word(CMD_READ, any_key(), pick_weight(), 1'b0, '0);
        words_sent += count + 1;
      end
    endcase
  endtask

  // stimulus
  initial begin : stimulus
    int words_sent;
    int target;
    int sat_hits;
    logic [KEY_W-1:0] hot_key;
    rst_ni              = 1'b0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.cmd         <= CMD_ADD;
    cmd_bus.item_key    <= '0;
    cmd_bus.item_weight <= '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      key_totals[i] = '0;
      key_marks[i]  = 1'b0;
    end
    live_keys      = 0;
    mismatch_count = 0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    snk_hold_req   = 0;
    words_sent     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DIR_LEN; i++)
      send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].weight,
                dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // drive the largest key to saturation with other traffic mixed in
    hot_key  = KEY_MAX;
    sat_hits = 0;
    while (sat_hits < 6) begin
      if ($urandom_range(5) == 0) begin
        if (live_keys > 1 && $urandom_range(1) == 0)
          send_word(CMD_READ, any_key(), pick_weight(), 1'b0, '0);
        else
          send_word(CMD_ADD, KEY_W'($urandom_range(KEY_SLOTS - 2)), pick_weight(), 1'b0, '0);
      end else begin
        send_word(CMD_ADD, hot_key, ($urandom_range(9) == 0) ? pick_weight() : WEIGHT_MAX,
                  1'b0, '0);
        if (key_totals[hot_key] == SUM_MAX) sat_hits++;
      end
      words_sent++;
    end
    repeat (live_keys + 1) send_word(CMD_READ, any_key(), pick_weight(), 1'b0, '0);
    wait_drained();

    // random traffic under each idling mode
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) run_episode(words_sent);
      wait_drained();
    end

    // long receiver hold-off while words keep coming, so the input backs up
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    snk_hold_req  = HOLD_OFF_CYCLES;
    target = words_sent + 40;
    while (words_sent < target) run_episode(words_sent);
    wait_drained();

    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // result checker and receiver ready
  initial begin : result_sink
    int    hold_left;
    pair_t got;
    pair_t want;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got = '{res_bus.found, res_bus.out_key, res_bus.total};
        if (owed_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: unexpected word found=%0d key=%0d total=%0d",
                     got.found, got.key, got.total);
        end else begin
          want = owed_pairs.pop_front();
          if (got.found !== want.found || got.key !== want.key || got.total !== want.total)
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected found=%0d key=%0d total=%0d, got %0d %0d %0d",
                       want.found, want.key, want.total, got.found, got.key, got.total);
          end
        end
      end
      if (hold_left == 0 && snk_hold_req > 0) begin
        hold_left    = snk_hold_req;
        snk_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // ends the run when no word moves on either side for too long
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
hdl/ksa_pkg.sv
hdl/ksa_in_if.sv
hdl/ksa_out_if.sv
hdl/ksa_ctrl.sv
hdl/ksa_dpath.sv
hdl/keyed_sum_aggregator_unit.sv
hdl/ksa_checker.sv
tb/sv/keyed_sum_aggregator_unit_tb.sv
